FILE: hdl/gm_pkg.sv
`default_nettype none

package gm_pkg;

  // pattern capacity and the width of a length count up to it
  localparam int PATTERN_MAX = 32;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  // wildcard bytes
  localparam logic [7:0] WILD_ONE = 8'h3F;
  localparam logic [7:0] WILD_ANY = 8'h2A;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_END    = 2'd3
  } gm_cmd_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       fire;
    gm_cmd_t    cmd;
    logic [7:0] chr;
  } gm_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/gm_cell.sv
`default_nettype none

module gm_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gm_pkg::gm_ctrl_t ctrl,
  input  wire logic             wr_en,
  input  wire logic             in_range,
  input  wire logic             head,
  input  wire logic             carry_in,
  input  wire logic             step_in,
  output logic                  carry_out,
  output logic                  step_out,
  output logic                  closed_out,
  output logic                  active_out
);
  import gm_pkg::*;

  logic [7:0] char_r;
  logic       active_r;
  logic       active_nxt;
  logic       is_star;
  logic       hit;

  // star closure ripples in from the left neighbour
  assign is_star    = (char_r == WILD_ANY);
  assign hit        = (char_r == WILD_ONE) || (char_r == ctrl.chr);
  assign closed_out = active_r | carry_in;
  assign carry_out  = closed_out & in_range & is_star;
  assign step_out   = closed_out & in_range & ~is_star & hit;
  assign active_out = active_r;

  // next active bit for each command
  always_comb begin
    active_nxt = active_r;
    if (ctrl.fire) begin
      case (ctrl.cmd)
        CMD_CLEAR:  active_nxt = head;
        CMD_APPEND: active_nxt = active_r;
        CMD_TEXT:   active_nxt = carry_out | step_in;
        CMD_END:    active_nxt = head;
        default:    active_nxt = active_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= head;
    end else begin
      active_r <= active_nxt;
    end
  end

  // pattern byte, loaded once per append at this position
  always_ff @(posedge clk) begin
    if (ctrl.fire && (ctrl.cmd == CMD_APPEND) && wr_en) begin
      char_r <= ctrl.chr;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/wildcard_glob_matcher.sv
// the result appears in the cycle after an accepted end-of-text transaction
// throughput: one transaction per cycle for every command while in_stall is low; no result for other commands
// the period is set by the star closure rippling through the row of cells
// synchronous reset clears pattern length, overflow and result valid,
// and leaves only position zero active; pattern bytes are not reset
`default_nettype none

module wildcard_glob_matcher (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_character,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_matched,
  output logic            out_pattern_overflow
);
  import gm_pkg::*;

  logic                 accept;
  gm_ctrl_t             ctrl;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 tail_r, tail_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_matched_r, out_matched_nxt;
  logic                 out_ovf_r, out_ovf_nxt;
  logic [PATTERN_MAX:0] carry;
  logic [PATTERN_MAX:0] step;
  logic [PATTERN_MAX:0] closed;
  logic [PATTERN_MAX:0] act_vec;
  logic                 full;

  // input handshake: take a transaction unless a result is blocked
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = (len_r == LEN_W'(PATTERN_MAX));

  assign ctrl.fire = accept;
  assign ctrl.cmd  = gm_cmd_t'(in_command);
  assign ctrl.chr  = in_character;

  assign carry[0] = 1'b0;
  assign step[0]  = 1'b0;

  // row of cells, one per pattern position
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
    gm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .wr_en      (len_r == LEN_W'(p)),
      .in_range   (LEN_W'(p) < len_r),
      .head       (p == 0),
      .carry_in   (carry[p]),
      .step_in    (step[p]),
      .carry_out  (carry[p+1]),
      .step_out   (step[p+1]),
      .closed_out (closed[p]),
      .active_out (act_vec[p])
    );
  end

  // final position, past the last byte of a full pattern
  assign closed[PATTERN_MAX]  = tail_r | carry[PATTERN_MAX];
  assign act_vec[PATTERN_MAX] = tail_r;

  // control next state and result
  always_comb begin
    len_nxt         = len_r;
    ovf_nxt         = ovf_r;
    tail_nxt        = tail_r;
    out_valid_nxt   = out_valid_r & out_stall;
    out_matched_nxt = out_matched_r;
    out_ovf_nxt     = out_ovf_r;
    if (accept) begin
      case (ctrl.cmd)
        CMD_CLEAR: begin
          len_nxt  = '0;
          ovf_nxt  = 1'b0;
          tail_nxt = 1'b0;
        end
        CMD_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            len_nxt = len_r + LEN_W'(1);
          end
        end
        CMD_TEXT: begin
          tail_nxt = step[PATTERN_MAX];
        end
        CMD_END: begin
          tail_nxt        = 1'b0;
          out_valid_nxt   = 1'b1;
          out_matched_nxt = closed[len_r];
          out_ovf_nxt     = ovf_r;
        end
        default: begin
          tail_nxt = tail_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = out_matched_r;
  assign out_pattern_overflow = out_ovf_r;

  // checks on length, overflow, restart, end-of-text result and the final position
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow flagged while pattern not full");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (ctrl.cmd == CMD_CLEAR || ctrl.cmd == CMD_END)
      |=> act_vec == (PATTERN_MAX+1)'(1))
    else $error("matching did not restart at position zero");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (ctrl.cmd == CMD_END) |=> out_valid_r)
    else $error("end of text gave no result");

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r |-> full)
    else $error("final position active with short pattern");

endmodule

`default_nettype wire
